/* sv/pgom_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgom_pkg
// Shared widths, codes and controller/datapath handshake types for the
// proximity grid owner map.
// ----------------------------------------------------------------------------
package pgom_pkg;

    localparam int GRID_CELLS_DEF  = 32;
    localparam int MAP_WIDTH_DEF   = 65536;
    localparam int MAX_OBJECTS_DEF = 64;

    localparam int FUNC_W = 2;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 18;
    localparam int RAD_W  = 13;

    localparam logic [RAD_W-1:0] RADIUS_RST = 13'd4500;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic ld_in;
        logic clr_start;
        logic clr_step;
        logic div_mul;
        logic div_back;
        logic div_fix;
        logic win_calc;
        logic org_calc;
        logic scan_step;
        logic fin;
        logic q_addr;
        logic q_read;
        logic out_load;
    } pgom_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              req_valid;
        logic [FUNC_W-1:0] req_func;
        logic [FUNC_W-1:0] func;
        logic              skip;
        logic              scan_last;
        logic              clr_last;
        logic              out_free;
    } pgom_sts_t;

endpackage
`default_nettype wire

/* sv/pgom_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgom_req_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface pgom_req_if
    import pgom_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [IDX_W-1:0]        object_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    last_object;

    modport source (
        output valid, func, object_index, pos_x, pos_y, last_object,
        input  ready
    );
    modport sink (
        input  valid, func, object_index, pos_x, pos_y, last_object,
        output ready
    );
endinterface
`default_nettype wire

/* sv/pgom_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgom_rsp_if
// Result channel: valid/ready handshake with the query result fields.
// ----------------------------------------------------------------------------
interface pgom_rsp_if
    import pgom_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [IDX_W-1:0] owner_index;

    modport source (
        output valid, hit, owner_index,
        input  ready
    );
    modport sink (
        input  valid, hit, owner_index,
        output ready
    );
endinterface
`default_nettype wire

/* sv/pgom_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgom_dp
// Datapath: item latch, three-lane constant divider, window setup, scan
// pipeline with distance test, owner memory, clear counter, result register.
// ----------------------------------------------------------------------------
module pgom_dp
    import pgom_pkg::*;
#(
    parameter int GRID_CELLS  = GRID_CELLS_DEF,
    parameter int MAP_WIDTH   = MAP_WIDTH_DEF,
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    pgom_req_if.sink               req,
    pgom_rsp_if.source             rsp,
    input  wire                    cfg_we,
    input  wire logic [RAD_W-1:0]  cfg_wdata,
    input  wire pgom_cmd_t         cmd,
    output pgom_sts_t              sts
);

    localparam int CELL   = MAP_WIDTH / GRID_CELLS;
    localparam int GIDX_W = $clog2(GRID_CELLS);
    localparam int DEPTH  = GRID_CELLS * GRID_CELLS;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAG_W  = POS_W;
    localparam int SH     = POS_W;          // reciprocal scale, above any magnitude
    localparam int RCP_W  = SH - 1;         // cell size is at least 4
    localparam int CW     = POS_W + 2;
    localparam int CTR_W  = POS_W + 3;      // cell centers, below 2^21
    localparam int DX_W   = CTR_W + 1;
    localparam int CRD_W  = POS_W;
    localparam int WIN_W  = POS_W + 1;
    localparam int SQ_W   = 2 * RAD_W;
    localparam int MAPC_W = POS_W + 3;
    localparam int OBJ_W  = 9;
    localparam int ENT_W  = IDX_W + 1;
    localparam int NLANE  = 3;              // x, y, radius

    localparam logic [RCP_W-1:0]        RECIP    = RCP_W'((2 ** SH) / CELL);
    localparam logic [CW-1:0]           CELL_C   = CW'(CELL);
    localparam logic [CTR_W-1:0]        CELL_CTR = CTR_W'(CELL);
    localparam logic [CTR_W-1:0]        HALF_CTR = CTR_W'(CELL / 2);
    localparam logic signed [WIN_W-1:0] GMAX_W   = WIN_W'(GRID_CELLS - 1);
    localparam logic signed [CRD_W-1:0] GMAX_C   = CRD_W'(GRID_CELLS - 1);
    localparam logic [GIDX_W-1:0]       GMAX_I   = GIDX_W'(GRID_CELLS - 1);
    localparam logic [AW-1:0]           GRID_A   = AW'(GRID_CELLS);
    localparam logic [AW-1:0]           DEPTH_LAST = AW'(DEPTH - 1);
    localparam logic [MAPC_W-1:0]       MAP_C    = MAPC_W'(MAP_WIDTH);
    localparam logic [OBJ_W-1:0]        MAXOBJ_C = OBJ_W'(MAX_OBJECTS);

    // latched item
    logic [FUNC_W-1:0]       func_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic                    last_reg;

    logic [RAD_W-1:0] rad_reg;
    logic             map_ready_reg;

    // divider lanes
    logic [MAG_W-1:0]        mag_reg [NLANE];
    logic [NLANE-1:0]        neg_reg;
    logic [RCP_W-1:0]        q0_reg  [NLANE];
    logic [MAG_W-1:0]        qc_reg  [NLANE];
    logic signed [CRD_W-1:0] crd_reg [NLANE];

    logic [MAG_W+RCP_W-1:0]  prod    [NLANE];
    logic [RCP_W+CW-1:0]     qc_full [NLANE];
    logic [MAG_W-1:0]        rem     [NLANE];
    logic [RCP_W-1:0]        q_fix   [NLANE];
    logic signed [CRD_W-1:0] crd_next[NLANE];

    // window
    logic signed [WIN_W-1:0] off_w;
    logic signed [WIN_W-1:0] lo_w  [2];
    logic signed [WIN_W-1:0] hi_w  [2];
    logic signed [WIN_W-1:0] loc_w [2];
    logic signed [WIN_W-1:0] hic_w [2];
    logic                    win_empty;
    logic [GIDX_W-1:0]       i0_reg, i1_reg, j0_reg, j1_reg;
    logic                    empty_reg;
    logic [SQ_W-1:0]         r2_reg;

    // scan counters
    logic [GIDX_W-1:0] i_reg, j_reg;
    logic [CTR_W-1:0]  cxc_reg, cyc_reg, cy0_reg;
    logic [AW-1:0]     row_reg;

    // distance stage
    logic signed [DX_W-1:0] dx, dy;
    logic [DX_W-1:0]        adx, ady;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic                   far_reg;
    logic [AW-1:0]          wa_reg;
    logic                   wv_reg;
    logic                   claim;

    // memory and query
    logic [ENT_W-1:0]  mem [DEPTH];
    logic [ENT_W-1:0]  rd_reg;
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     qa_reg;
    logic              qok_reg;
    logic              q_ok;
    logic [GIDX_W-1:0] ci, cj;

    logic             out_valid_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] own_reg;

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            func_reg   <= req.func;
            idx_reg    <= req.object_index;
            px_reg     <= req.pos_x;
            py_reg     <= req.pos_y;
            last_reg   <= req.last_object;
            mag_reg[0] <= req.pos_x[POS_W-1] ? MAG_W'(-req.pos_x) : MAG_W'(req.pos_x);
            mag_reg[1] <= req.pos_y[POS_W-1] ? MAG_W'(-req.pos_y) : MAG_W'(req.pos_y);
            mag_reg[2] <= MAG_W'(rad_reg);
            neg_reg    <= {1'b0, req.pos_y[POS_W-1], req.pos_x[POS_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg <= RADIUS_RST;
        end
        else if (cfg_we)
        begin
            rad_reg <= cfg_wdata;
        end
    end

    // divide by cell size: reciprocal multiply, then one correction step
    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            prod[l]     = MAG_W'(mag_reg[l]) * (MAG_W + RCP_W)'(RECIP);
            qc_full[l]  = (RCP_W + CW)'(q0_reg[l]) * (RCP_W + CW)'(CELL_C);
            rem[l]      = mag_reg[l] - qc_reg[l];
            q_fix[l]    = q0_reg[l] + RCP_W'(CW'(rem[l]) >= CELL_C);
            crd_next[l] = neg_reg[l] ? -CRD_W'(q_fix[l]) : CRD_W'(q_fix[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            if (cmd.div_mul)
            begin
                q0_reg[l] <= prod[l][SH +: RCP_W];
            end
            if (cmd.div_back)
            begin
                qc_reg[l] <= qc_full[l][MAG_W-1:0];
            end
            if (cmd.div_fix)
            begin
                crd_reg[l] <= crd_next[l];
            end
        end
    end

    // window bounds, clamped to the grid
    always_comb
    begin
        off_w = {crd_reg[2][CRD_W-1], crd_reg[2]} + WIN_W'(1);
        for (int l = 0; l < 2; l++)
        begin
            lo_w[l]  = {crd_reg[l][CRD_W-1], crd_reg[l]} - off_w;
            hi_w[l]  = {crd_reg[l][CRD_W-1], crd_reg[l]} + off_w;
            loc_w[l] = lo_w[l][WIN_W-1] ? '0 : lo_w[l];
            hic_w[l] = (hi_w[l] > GMAX_W) ? GMAX_W : hi_w[l];
        end
        win_empty = (loc_w[0] > hic_w[0]) || (loc_w[1] > hic_w[1]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_calc)
        begin
            i0_reg    <= loc_w[0][GIDX_W-1:0];
            i1_reg    <= hic_w[0][GIDX_W-1:0];
            j0_reg    <= loc_w[1][GIDX_W-1:0];
            j1_reg    <= hic_w[1][GIDX_W-1:0];
            empty_reg <= win_empty;
            r2_reg    <= SQ_W'(rad_reg) * SQ_W'(rad_reg);
        end
    end

    // scan counters walk the window column by column
    always_ff @(posedge clk)
    begin
        if (cmd.org_calc)
        begin
            i_reg   <= i0_reg;
            j_reg   <= j0_reg;
            cxc_reg <= CTR_W'(i0_reg) * CELL_CTR + HALF_CTR;
            cyc_reg <= CTR_W'(j0_reg) * CELL_CTR + HALF_CTR;
            cy0_reg <= CTR_W'(j0_reg) * CELL_CTR + HALF_CTR;
            row_reg <= AW'(i0_reg) * GRID_A;
        end
        else if (cmd.scan_step)
        begin
            if (j_reg == j1_reg)
            begin
                j_reg   <= j0_reg;
                cyc_reg <= cy0_reg;
                i_reg   <= i_reg + 1'b1;
                cxc_reg <= cxc_reg + CELL_CTR;
                row_reg <= row_reg + GRID_A;
            end
            else
            begin
                j_reg   <= j_reg + 1'b1;
                cyc_reg <= cyc_reg + CELL_CTR;
            end
        end
    end

    // distances; anything at or beyond 2^13 is out of reach of the radius
    always_comb
    begin
        dx  = {{(DX_W-POS_W){px_reg[POS_W-1]}}, px_reg} - DX_W'(cxc_reg);
        dy  = {{(DX_W-POS_W){py_reg[POS_W-1]}}, py_reg} - DX_W'(cyc_reg);
        adx = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
        ady = dy[DX_W-1] ? DX_W'(-dy) : DX_W'(dy);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            sqx_reg <= SQ_W'(adx[RAD_W-1:0]) * SQ_W'(adx[RAD_W-1:0]);
            sqy_reg <= SQ_W'(ady[RAD_W-1:0]) * SQ_W'(ady[RAD_W-1:0]);
            far_reg <= (|adx[DX_W-1:RAD_W]) || (|ady[DX_W-1:RAD_W]);
            wa_reg  <= row_reg + AW'(j_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
        end
        else
        begin
            wv_reg <= cmd.scan_step;
        end
    end

    assign claim = wv_reg && !far_reg &&
                   (({1'b0, sqx_reg} + {1'b0, sqy_reg}) <= {1'b0, r2_reg});

    // owner memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_reg] <= '0;
        end
        else if (claim)
        begin
            mem[wa_reg] <= {1'b1, idx_reg};
        end
        if (cmd.q_read)
        begin
            rd_reg <= mem[qa_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_start)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_ready_reg <= 1'b0;
        end
        else if (cmd.clr_start)
        begin
            map_ready_reg <= 1'b0;
        end
        else if (cmd.fin && last_reg)
        begin
            map_ready_reg <= 1'b1;
        end
    end

    // query cell, saturated at the last row and column
    always_comb
    begin
        q_ok = map_ready_reg &&
               !px_reg[POS_W-1] && ({3'b000, px_reg} < MAP_C) &&
               !py_reg[POS_W-1] && ({3'b000, py_reg} < MAP_C);
        ci   = (crd_reg[0] > GMAX_C) ? GMAX_I : crd_reg[0][GIDX_W-1:0];
        cj   = (crd_reg[1] > GMAX_C) ? GMAX_I : crd_reg[1][GIDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_addr)
        begin
            qa_reg  <= AW'(ci) * GRID_A + AW'(cj);
            qok_reg <= q_ok;
        end
        if (cmd.out_load)
        begin
            hit_reg <= qok_reg && rd_reg[IDX_W];
            own_reg <= (qok_reg && rd_reg[IDX_W]) ? rd_reg[IDX_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign req.ready       = cmd.in_ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.owner_index = own_reg;

    always_comb
    begin
        sts.req_valid = req.valid;
        sts.req_func  = req.func;
        sts.func      = func_reg;
        sts.skip      = empty_reg || ({3'b000, idx_reg} >= MAXOBJ_C);
        sts.scan_last = (i_reg == i1_reg) && (j_reg == j1_reg);
        sts.clr_last  = (clr_reg == DEPTH_LAST);
        sts.out_free  = !out_valid_reg || rsp.ready;
    end

endmodule
`default_nettype wire

/* sv/pgom_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pgom_ctrl
// Controller: sequences clear sweep, divide, window scan and query lookup.
// ----------------------------------------------------------------------------
module pgom_ctrl
    import pgom_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire pgom_sts_t sts,
    output pgom_cmd_t      cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_DIV2  = 4'd3;
    localparam logic [3:0] S_DIV3  = 4'd4;
    localparam logic [3:0] S_WIN   = 4'd5;
    localparam logic [3:0] S_ORG   = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_DRAIN = 4'd8;
    localparam logic [3:0] S_QADDR = 4'd9;
    localparam logic [3:0] S_QREAD = 4'd10;
    localparam logic [3:0] S_QOUT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;     // memory sweep after reset
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.req_valid)
                begin
                    cmd.ld_in = 1'b1;
                    case (sts.req_func)
                        FUNC_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLR;
                        end
                        FUNC_PLACE, FUNC_QUERY:
                        begin
                            state_next = S_DIV1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV1:
            begin
                cmd.div_mul = 1'b1;
                state_next  = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_back = 1'b1;
                state_next   = S_DIV3;
            end
            S_DIV3:
            begin
                cmd.div_fix = 1'b1;
                state_next  = (sts.func == FUNC_PLACE) ? S_WIN : S_QADDR;
            end
            S_WIN:
            begin
                cmd.win_calc = 1'b1;
                state_next   = S_ORG;
            end
            S_ORG:
            begin
                cmd.org_calc = 1'b1;
                if (sts.skip)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            S_QADDR:
            begin
                cmd.q_addr = 1'b1;
                state_next = S_QREAD;
            end
            S_QREAD:
            begin
                cmd.q_read = 1'b1;
                state_next = S_QOUT;
            end
            S_QOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/proximity_grid_owner_map_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_grid_owner_map_unit
// Square grid of cells over a square map; each cell remembers the last
// object placed near it, and point queries return that owner.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the owner memory with req.ready
// low; cfg writes are taken at any time but should only be made while
// the block is idle. Items are processed one at a time by a
// controller/datapath pair and req.ready is high only while the block
// waits for a new item. A query passes through the idle state in which
// the item's transfer is taken, three steps in the reciprocal-multiply
// divider that maps a position to a cell, the cell address, the
// registered memory read and the load of the result register. A place
// item passes through idle, three divider steps, window bounds and scan
// setup, then scans its clamped window (the memory write port takes one
// cell per cycle), then drains the distance stage; an object index at
// or above MAX_OBJECTS or a window off the grid skips the scan. A clear
// item sweeps the whole memory. Unused function codes are dropped. A
// result waiting in the output register does not block new items; only
// a later query waits for it to be taken.
// ----------------------------------------------------------------------------
module proximity_grid_owner_map_unit
    import pgom_pkg::*;
#(
    parameter int GRID_CELLS  = GRID_CELLS_DEF,
    parameter int MAP_WIDTH   = MAP_WIDTH_DEF,
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    pgom_req_if.sink              req,
    pgom_rsp_if.source            rsp,
    input  wire                   cfg_we,
    input  wire logic [RAD_W-1:0] cfg_wdata
);

    // command / status between sequencer and datapath
    pgom_cmd_t cmd;
    pgom_sts_t sts;

    // controller: one state per divider step, plus states for window setup, scan and lookup
    pgom_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: holds the radius register, the owner memory and the
    // output register; drives req.ready from the controller's command
    pgom_dp #(
        .GRID_CELLS  (GRID_CELLS),
        .MAP_WIDTH   (MAP_WIDTH),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the proximity grid owner map. Clear, place and
// query transfers go in with random bursts and gaps while the result side
// stalls on its own pattern. A model of the owner grid works out every
// query answer, and each result transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import pgom_pkg::*;

    localparam int GRID      = GRID_CELLS_DEF;
    localparam int MAP_W     = MAP_WIDTH_DEF;
    localparam int OBJ_LIMIT = MAX_OBJECTS_DEF;
    localparam int SPAN      = MAP_W / GRID;          // map units per cell

    // func code 3 is not used by the block; it must be dropped silently
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    localparam logic [RAD_W-1:0] RADIUS_MAX = 13'd6143;

    // a clear sweeps the whole grid and gives no result, so this is the
    // quiet time needed before the block is known to be idle
    localparam int SETTLE_CYCLES = GRID * GRID + 64;
    localparam int LONG_HOLD     = 300;    // result-side hold-off, cycles
    localparam int END_LIMIT     = 20000;  // bound on the final drain
    localparam int MAX_REPORTS   = 40;
    localparam int ITEMS_PER_RADIUS = 160;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic [IDX_W-1:0]        idx;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    last;
    } grid_op_t;

    typedef struct {
        logic             hit;
        logic [IDX_W-1:0] owner;
    } owner_answer_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [RAD_W-1:0] cfg_wdata = '0;

    pgom_req_if req_ch ();
    pgom_rsp_if rsp_ch ();

    proximity_grid_owner_map_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model state: one entry per cell, bit 6 = owned, bits 5:0 = owner index.
    // ------------------------------------------------------------------------
    logic [6:0]       owner_grid [GRID*GRID];
    logic             grid_ready;
    logic [RAD_W-1:0] claim_radius;
    owner_answer_t    answers_due [$];   // query answers not yet returned

    int errors        = 0;
    int burst_left    = 0;               // transfers left in current burst
    int hold_requests = 0;               // long holds asked by the tests
    int holds_served  = 0;               // long holds done by the receiver

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void clear_grid();
        foreach (owner_grid[k])
            owner_grid[k] = '0;
        grid_ready = 1'b0;
    endfunction

    // Every cell whose centre is within the radius (squared integer
    // distance) takes the object. Window is clamped on both axes.
    function automatic void claim_cells(int idx, longint px, longint py);
        longint reach, r2, cx, cy, i0, i1, j0, j1, dx, dy, i, j;
        reach = longint'(claim_radius) / SPAN + 1;
        r2    = longint'(claim_radius) * longint'(claim_radius);
        cx    = px / SPAN;               // truncates toward zero
        cy    = py / SPAN;
        i0 = cx - reach;
        i1 = cx + reach;
        j0 = cy - reach;
        j1 = cy + reach;
        if (idx >= OBJ_LIMIT)
            return;
        if (i0 < 0) i0 = 0;
        if (j0 < 0) j0 = 0;
        if (i1 > GRID - 1) i1 = GRID - 1;
        if (j1 > GRID - 1) j1 = GRID - 1;
        for (i = i0; i <= i1; i++)
        begin
            for (j = j0; j <= j1; j++)
            begin
                dx = px - (i * SPAN + SPAN / 2);
                dy = py - (j * SPAN + SPAN / 2);
                if (dx * dx + dy * dy <= r2)
                    owner_grid[int'(i * GRID + j)] = {1'b1, idx[IDX_W-1:0]};
            end
        end
    endfunction

    // Advance the model by one accepted transfer; queries queue an answer.
    function automatic void apply_grid_op(grid_op_t op);
        longint        px, py;
        longint        ci, cj;
        logic [6:0]    entry;
        owner_answer_t ans;
        px = longint'(op.x);
        py = longint'(op.y);
        case (op.func)
            FUNC_CLEAR: clear_grid();
            FUNC_PLACE:
            begin
                claim_cells(int'(op.idx), px, py);
                if (op.last)
                    grid_ready = 1'b1;
            end
            FUNC_QUERY:
            begin
                ans.hit   = 1'b0;
                ans.owner = '0;
                // off-map points and a map not yet ready answer no hit
                if (grid_ready && px >= 0 && py >= 0 && px < MAP_W && py < MAP_W)
                begin
                    ci = px / SPAN;
                    cj = py / SPAN;
                    if (ci > GRID - 1) ci = GRID - 1;
                    if (cj > GRID - 1) cj = GRID - 1;
                    entry = owner_grid[int'(ci * GRID + cj)];
                    if (entry[6])
                    begin
                        ans.hit   = 1'b1;
                        ans.owner = entry[IDX_W-1:0];
                    end
                end
                answers_due.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    function automatic grid_op_t mk_op(logic [FUNC_W-1:0] f, int idx, int x, int y,
                                       bit last);
        grid_op_t op;
        op.func = f;
        op.idx  = idx[IDX_W-1:0];
        op.x    = x[POS_W-1:0];
        op.y    = y[POS_W-1:0];
        op.last = last;
        return op;
    endfunction

    // One coordinate: mostly inside the map, with cell centres (so a zero
    // radius still claims), map edges and the full signed range mixed in.
    function automatic int map_coord();
        case ($urandom_range(0, 7))
            0: return int'($urandom_range(0, GRID - 1)) * SPAN + SPAN / 2;
            1: return $urandom_range(0, 1) ? int'($urandom_range(0, 63))
                                           : MAP_W - 1 - int'($urandom_range(0, 63));
            2: return int'($urandom_range(0, 262143)) - 131072;
            default: return int'($urandom_range(0, MAP_W - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Called right after a rising edge. Valid stays high across
    // back-to-back transfers inside a burst; a gap lowers it first. Each
    // call leaves valid high, so anything else that consumes time must go
    // through drain() which lowers it.
    // ------------------------------------------------------------------------
    task automatic send_op(grid_op_t op);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.func         <= op.func;
        req_ch.object_index <= op.idx;
        req_ch.pos_x        <= op.x;
        req_ch.pos_y        <= op.y;
        req_ch.last_object  <= op.last;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_grid_op(op);
    endtask

    // Stop offering, wait for every pending answer, then let the block
    // finish any clear or place that has no result of its own.
    task automatic drain(int settle);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_radius(logic [RAD_W-1:0] r);
        drain(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        claim_radius = r;
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready follows a random bit pattern, reloaded in chunks
    // (all ones gives stall-free stretches). A long hold asked by a test is
    // counted here, in this process.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        logic [31:0] pattern;
        int          left;
        pattern = '1;
        left    = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
            end
            else
            begin
                if (left == 0)
                begin
                    left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = $urandom;
                        2: pattern = $urandom | $urandom;
                        default: pattern = $urandom & $urandom;
                    endcase
                end
                rsp_ch.ready <= pattern[0];
                pattern = {pattern[0], pattern[31:1]};
                left--;
            end
        end
    end

    // Every result transfer is matched against the oldest pending answer.
    always @(posedge clk)
    begin : result_check
        owner_answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (answers_due.size() == 0)
                report_mismatch("result transfer with no query pending");
            else
            begin
                want = answers_due.pop_front();
                if (rsp_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit got %b want %b",
                                              rsp_ch.hit, want.hit));
                if (rsp_ch.owner_index !== want.owner)
                    report_mismatch($sformatf("owner_index got %0d want %0d",
                                              rsp_ch.owner_index, want.owner));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Queries before the map is ready, a place without the last flag, an
    // unused func code, and a clear that takes readiness away again.
    task automatic test_early_query();
        send_op(mk_op(FUNC_QUERY, 0, 30000, 30000, 1'b0));
        send_op(mk_op(FUNC_PLACE, 9, 30000, 30000, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, 30000, 30000, 1'b0));
        send_op(mk_op(FUNC_NONE, 63, -1, -1, 1'b1));
        send_op(mk_op(FUNC_PLACE, 10, 30500, 30000, 1'b1));
        send_op(mk_op(FUNC_QUERY, 0, 30000, 30000, 1'b0));
        send_op(mk_op(FUNC_CLEAR, 0, 0, 0, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, 30000, 30000, 1'b0));
    endtask

    // Field extremes: map corners, the far ends of the signed range (window
    // wholly off the grid), windows partly off the grid, off-map queries.
    task automatic test_field_extremes();
        send_op(mk_op(FUNC_PLACE, 0, 0, 0, 1'b0));
        send_op(mk_op(FUNC_PLACE, 63, MAP_W - 1, MAP_W - 1, 1'b0));
        send_op(mk_op(FUNC_PLACE, 21, -131072, -131072, 1'b0));
        send_op(mk_op(FUNC_PLACE, 7, -100, 30000, 1'b0));
        send_op(mk_op(FUNC_PLACE, 42, 131071, 131071, 1'b1));
        send_op(mk_op(FUNC_QUERY, 0, 0, 0, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, MAP_W - 1, MAP_W - 1, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, 1000, 30000, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, -1, 0, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, 0, -1, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, MAP_W, 10, 1'b0));
        send_op(mk_op(FUNC_QUERY, 0, 10, MAP_W, 1'b0));
        send_op(mk_op(FUNC_QUERY, 63, -131072, 131071, 1'b1));
        send_op(mk_op(FUNC_QUERY, 0, 131071, -131072, 1'b0));
    endtask

    // Result side holds off for a long stretch while queries keep coming:
    // the output register fills and the block must stall its input. Then
    // the sender waits until every answer is back.
    task automatic test_backpressure();
        int k;
        hold_requests++;
        for (k = 0; k < 40; k++)
        begin
            if (k % 8 == 0)
                send_op(mk_op(FUNC_PLACE, $urandom_range(0, OBJ_LIMIT - 1),
                              map_coord(), map_coord(), 1'b1));
            else
                send_op(mk_op(FUNC_QUERY, 0, map_coord(), map_coord(), 1'b0));
        end
        drain(1);
    endtask

    // A well-formed scene: optional clear, a set of places with the last
    // flag (usually) on the final one, then queries aimed mostly near the
    // placed objects. Stray transfers are mixed in as noise.
    task automatic run_scene(ref int sent);
        int obj_x [$];
        int obj_y [$];
        int n_obj, n_qry, k, pick, reach, qx, qy;
        bit last;
        grid_op_t op;
        if ($urandom_range(0, 2) == 0)
        begin
            send_op(mk_op(FUNC_CLEAR, $urandom_range(0, 63), map_coord(), map_coord(),
                          $urandom_range(0, 1)));
            sent++;
        end
        n_obj = $urandom_range(1, 10);
        for (k = 0; k < n_obj; k++)
        begin
            if (k == n_obj - 1)
                last = ($urandom_range(0, 7) != 0);
            else
                last = ($urandom_range(0, 15) == 0);
            op = mk_op(FUNC_PLACE, $urandom_range(0, OBJ_LIMIT - 1),
                       map_coord(), map_coord(), last);
            obj_x.push_back(int'(op.x));
            obj_y.push_back(int'(op.y));
            send_op(op);
            sent++;
        end
        reach = int'(claim_radius) + SPAN;
        n_qry = $urandom_range(4, 24);
        for (k = 0; k < n_qry; k++)
        begin
            // noise: unused code (not counted), or a fully random transfer
            if ($urandom_range(0, 15) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_op(mk_op(FUNC_NONE, $urandom, $urandom, $urandom, $urandom));
                    1:
                    begin
                        send_op(mk_op(FUNC_QUERY, $urandom, $urandom, $urandom,
                                      $urandom));
                        sent++;
                    end
                    default:
                    begin
                        send_op(mk_op(FUNC_PLACE, $urandom, $urandom, $urandom,
                                      $urandom));
                        sent++;
                    end
                endcase
            end
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                pick = $urandom_range(0, obj_x.size() - 1);
                qx = obj_x[pick] + int'($urandom_range(0, 2 * reach)) - reach;
                qy = obj_y[pick] + int'($urandom_range(0, 2 * reach)) - reach;
            end
            else if (pick < 17)
            begin
                qx = $urandom_range(0, MAP_W - 1);
                qy = $urandom_range(0, MAP_W - 1);
            end
            else
            begin
                qx = map_coord();
                qy = map_coord();
            end
            send_op(mk_op(FUNC_QUERY, $urandom_range(0, 63), qx, qy,
                          $urandom_range(0, 1)));
            sent++;
        end
    endtask

    // Random scenes under a series of radius settings, extremes included;
    // the radius is only changed once the block has gone quiet.
    task automatic test_random_scenes();
        logic [RAD_W-1:0] radii [7];
        int p, sent;
        radii[0] = RADIUS_MAX;
        radii[1] = '0;
        radii[2] = 13'd2048;
        radii[3] = 13'd2047;
        radii[4] = $urandom_range(1, RADIUS_MAX);
        radii[5] = 13'd1;
        radii[6] = RADIUS_RST;
        for (p = 0; p < 7; p++)
        begin
            set_radius(radii[p]);
            sent = 0;
            while (sent < ITEMS_PER_RADIUS)
                run_scene(sent);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        int w;
        req_ch.valid        <= 1'b0;
        req_ch.func         <= FUNC_CLEAR;
        req_ch.object_index <= '0;
        req_ch.pos_x        <= '0;
        req_ch.pos_y        <= '0;
        req_ch.last_object  <= 1'b0;
        clear_grid();
        claim_radius = RADIUS_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // the block clears its memory after reset; send_op simply waits
        test_early_query();
        test_field_extremes();
        test_backpressure();
        test_random_scenes();

        req_ch.valid <= 1'b0;
        for (w = 0; w < END_LIMIT && answers_due.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (answers_due.size() != 0)
            report_mismatch($sformatf("%0d query answers never returned",
                                      answers_due.size()));

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a bound far beyond the slowest legal run.
    initial
    begin : watchdog
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/pgom_pkg.sv
sv/pgom_req_if.sv
sv/pgom_rsp_if.sv
sv/pgom_dp.sv
sv/pgom_ctrl.sv
sv/proximity_grid_owner_map_unit.sv
verif/tb_top.sv
